// File: rtl/vfrs_pkg.sv
// Shared types, field widths and codes for the running-sums variance block.
package vfrs_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SUM_SQ_W   = 46;
  localparam int SUM_VAL_W  = 32;
  localparam int COUNT_W    = 16;
  localparam int REQ_W      = 3;
  localparam int RESULT_W   = 64;
  localparam int STATUS_W   = 3;

  // request codes
  localparam logic [REQ_W-1:0] MODE_RAW   = 3'd0;
  localparam logic [REQ_W-1:0] MODE_RMSD  = 3'd1;
  localparam logic [REQ_W-1:0] MODE_NRMSD = 3'd2;
  localparam logic [REQ_W-1:0] MODE_STDEV = 3'd3;
  localparam logic [REQ_W-1:0] MODE_CV    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEG_VAR    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_MEAN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAT        = 3'd4;

  typedef struct packed {
    logic        [SUM_SQ_W-1:0]  sum_sq;
    logic signed [SUM_VAL_W-1:0] sum_values;
    logic        [COUNT_W-1:0]   num_samples;
    logic        [REQ_W-1:0]     req_type;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic        [STATUS_W-1:0] status;
  } out_item_t;

endpackage

// File: rtl/vfrs_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module vfrs_div
  import vfrs_pkg::*;
#(
  parameter int NW   = 8,
  parameter int DENW = 8,
  parameter int SBW  = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NW-1:0]   in_num,
  input  logic [DENW-1:0] in_den,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_valid,
  output logic [NW-1:0]   out_quo,
  output logic            out_rem_zero,
  output logic [SBW-1:0]  out_sb
);

  logic [NW-1:0]   num_r [NW+1];
  logic [DENW-1:0] rem_r [NW+1];
  logic [DENW-1:0] den_r [NW+1];
  logic [SBW-1:0]  sb_r  [NW+1];
  logic [NW:0]     vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= in_num;
      rem_r[0] <= '0;
      den_r[0] <= in_den;
      sb_r[0]  <= in_sb;
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [DENW:0]   trial;
    logic [DENW:0]   diff;
    logic            ge;
    logic [DENW-1:0] rem_nxt;
    logic [NW-1:0]   num_nxt;

    always_comb begin
      trial   = {rem_r[k-1], num_r[k-1][NW-1]};
      diff    = trial - {1'b0, den_r[k-1]};
      ge      = (trial >= {1'b0, den_r[k-1]});
      rem_nxt = ge ? diff[DENW-1:0] : trial[DENW-1:0];
      num_nxt = {num_r[k-1][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_nxt;
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
    end
  end

  assign out_valid    = vld_r[NW];
  assign out_quo      = num_r[NW];
  assign out_rem_zero = (rem_r[NW] == '0);
  assign out_sb       = sb_r[NW];

endmodule

// File: rtl/vfrs_sqrt.sv
// Pipelined digit-by-digit floor square root, one root bit per register stage.
module vfrs_sqrt
  import vfrs_pkg::*;
#(
  parameter int XW  = 8,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [XW-1:0]     in_x,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_valid,
  output logic [XW/2-1:0]   out_root,
  output logic              out_exact,
  output logic [SBW-1:0]    out_sb
);

  localparam int RW  = XW / 2;
  localparam int RMW = RW + 1;

  logic [XW-1:0]  x_r    [RW+1];
  logic [RMW-1:0] rem_r  [RW+1];
  logic [RW-1:0]  root_r [RW+1];
  logic [SBW-1:0] sb_r   [RW+1];
  logic [RW:0]    vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= in_x;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      sb_r[0]   <= in_sb;
    end
  end

  for (genvar k = 1; k <= RW; k++) begin : g_stage
    logic [RMW+1:0] rem2;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] diff;
    logic           ge;
    logic [RMW-1:0] rem_nxt;
    logic [RW-1:0]  root_nxt;
    logic [XW-1:0]  x_nxt;

    always_comb begin
      rem2     = {rem_r[k-1], x_r[k-1][XW-1 -: 2]};
      trial    = {1'b0, root_r[k-1], 2'b01};
      diff     = rem2 - trial;
      ge       = (rem2 >= trial);
      rem_nxt  = ge ? diff[RMW-1:0] : rem2[RMW-1:0];
      root_nxt = {root_r[k-1][RW-2:0], ge};
      x_nxt    = {x_r[k-1][XW-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= sb_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[RW];
  assign out_root  = root_r[RW];
  assign out_exact = (rem_r[RW] == '0);
  assign out_sb    = sb_r[RW];

endmodule

// File: rtl/variance_from_running_sums.sv
// Top level: spread statistics (raw D, rmsd, stdev, ratios to mean) from running sums.
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries a sum of squares, a sum, a count
//   and a request code. Output channel out_valid / out_stall / out_item returns one
//   item per input: a signed fixed-point value with FRAC_BITS fraction bits and a status.
//   An item moves when valid is high and stall is low.
// Throughput: one item per cycle while out_stall does not hold the pipe. Every stage is a register; nothing iterates.
// Depth: NUMW = DW + COUNT_BITS + 2*FRAC_BITS, RW = ceil(NUMW/2), and DW = 63 at defaults.
//   The depth comes from the bit-per-stage pre-divider (NUMW stages), the square root and
//   the post-divider (RW stages each).
// Stall: the whole pipe moves on one enable. It advances whenever the output register
//   is empty or being taken; otherwise in_stall rises and every stage holds.
// Reset: synchronous, active low; clears the valid bits only, the pipe comes up empty.
module variance_from_running_sums
  import vfrs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // n*S2 width, |D| width, D*n width
  localparam int PW_  = SUM_SQ_W + COUNT_BITS;
  localparam int EW   = (PW_ > 64) ? PW_ : 64;
  localparam int DW   = (PW_ > 63) ? PW_ : 63;
  localparam int HW   = DW - 32;
  localparam int PLW  = 32 + COUNT_BITS;
  localparam int PHW  = HW + COUNT_BITS;
  localparam int DNW  = DW + COUNT_BITS;
  // pre-divider numerator, square root input and root widths
  localparam int NUMW = DNW + 2 * FRAC_BITS;
  localparam int XW   = NUMW + (NUMW % 2);
  localparam int RW   = XW / 2;
  localparam int RAWW = DW + FRAC_BITS;
  localparam int D1W  = 2 * COUNT_BITS;
  localparam int D2W  = (COUNT_BITS > SUM_VAL_W) ? COUNT_BITS : SUM_VAL_W;
  localparam int MW   = ((RAWW > RW) ? RAWW : RW) + 1;
  localparam int CW   = (MW > RESULT_W) ? MW : RESULT_W + 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                vneg;   // result is negative
    logic                raw;    // value bypasses root and post-divide
    logic                zero;   // forced zero result
    logic [D2W-1:0]      den2;   // post-divide divisor
  } ctl_t;

  typedef struct packed {
    ctl_t            ctl;
    logic            ex;        // everything before the post-divide was exact
    logic [RAWW-1:0] rawv;
  } tail_t;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 0: input register, magnitude of the sum
  logic                  v0_r;
  logic [SUM_SQ_W-1:0]   s2_0_r;
  logic [SUM_VAL_W-1:0]  a_0_r, a_0_nxt;
  logic                  sneg_0_r;
  logic [COUNT_BITS-1:0] n_0_r;
  logic [REQ_W-1:0]      mode_0_r;

  assign a_0_nxt = in_item.sum_values[SUM_VAL_W-1]
                   ? (SUM_VAL_W'(0) - $unsigned(in_item.sum_values))
                   : $unsigned(in_item.sum_values);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_0_r   <= in_item.sum_sq;
      a_0_r    <= a_0_nxt;
      sneg_0_r <= in_item.sum_values[SUM_VAL_W-1];
      n_0_r    <= COUNT_BITS'(in_item.num_samples);
      mode_0_r <= in_item.req_type;
    end
  end

  // ---------------- stage 1: n*S2, S*S, n*(n-1)
  logic                  v1_r;
  logic [PW_-1:0]        p_1_r, p_1_nxt;
  logic [63:0]           q_1_r, q_1_nxt;
  logic [D1W-1:0]        nn1_1_r, nn1_1_nxt;
  logic [SUM_SQ_W-1:0]   s2_1_r;
  logic [SUM_VAL_W-1:0]  a_1_r;
  logic                  sneg_1_r;
  logic [COUNT_BITS-1:0] n_1_r;
  logic [REQ_W-1:0]      mode_1_r;

  assign p_1_nxt   = PW_'(n_0_r) * PW_'(s2_0_r);
  assign q_1_nxt   = 64'(a_0_r) * 64'(a_0_r);
  assign nn1_1_nxt = D1W'(n_0_r) * D1W'(n_0_r - COUNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_1_r    <= p_1_nxt;
      q_1_r    <= q_1_nxt;
      nn1_1_r  <= nn1_1_nxt;
      s2_1_r   <= s2_0_r;
      a_1_r    <= a_0_r;
      sneg_1_r <= sneg_0_r;
      n_1_r    <= n_0_r;
      mode_1_r <= mode_0_r;
    end
  end

  // ---------------- stage 2: D = n*S2 - S*S as sign and magnitude
  logic                  v2_r;
  logic [EW-1:0]         pe, qe;
  logic                  dneg_2_nxt, dneg_2_r;
  logic [DW-1:0]         d_2_nxt, d_2_r;
  logic [D1W-1:0]        nn1_2_r;
  logic [SUM_SQ_W-1:0]   s2_2_r;
  logic [SUM_VAL_W-1:0]  a_2_r;
  logic                  sneg_2_r;
  logic [COUNT_BITS-1:0] n_2_r;
  logic [REQ_W-1:0]      mode_2_r;

  always_comb begin
    pe         = EW'(p_1_r);
    qe         = EW'(q_1_r);
    dneg_2_nxt = (pe < qe);
    d_2_nxt    = dneg_2_nxt ? DW'(qe - pe) : DW'(pe - qe);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dneg_2_r <= dneg_2_nxt;
      d_2_r    <= d_2_nxt;
      nn1_2_r  <= nn1_1_r;
      s2_2_r   <= s2_1_r;
      a_2_r    <= a_1_r;
      sneg_2_r <= sneg_1_r;
      n_2_r    <= n_1_r;
      mode_2_r <= mode_1_r;
    end
  end

  // ---------------- stage 3: partial products of D*n
  logic                  v3_r;
  logic [PLW-1:0]        pl_3_r, pl_3_nxt;
  logic [PHW-1:0]        ph_3_r, ph_3_nxt;
  logic                  dneg_3_r;
  logic [DW-1:0]         d_3_r;
  logic [D1W-1:0]        nn1_3_r;
  logic [SUM_SQ_W-1:0]   s2_3_r;
  logic [SUM_VAL_W-1:0]  a_3_r;
  logic                  sneg_3_r;
  logic [COUNT_BITS-1:0] n_3_r;
  logic [REQ_W-1:0]      mode_3_r;

  assign pl_3_nxt = PLW'(d_2_r[31:0]) * PLW'(n_2_r);
  assign ph_3_nxt = PHW'(d_2_r[DW-1:32]) * PHW'(n_2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_3_r   <= pl_3_nxt;
      ph_3_r   <= ph_3_nxt;
      dneg_3_r <= dneg_2_r;
      d_3_r    <= d_2_r;
      nn1_3_r  <= nn1_2_r;
      s2_3_r   <= s2_2_r;
      a_3_r    <= a_2_r;
      sneg_3_r <= sneg_2_r;
      n_3_r    <= n_2_r;
      mode_3_r <= mode_2_r;
    end
  end

  // ---------------- operand select: numerator, two divisors, control
  // Modes without a pre-divide use divisor one; raw D rides the pre-divider
  // unchanged and is picked off at its output.
  logic [DNW-1:0]  dn;
  logic [NUMW-1:0] num_4;
  logic [D1W-1:0]  den1_4;
  ctl_t            ctl_4;

  always_comb begin
    dn     = DNW'(pl_3_r) + (DNW'(ph_3_r) << 32);
    num_4  = '0;
    den1_4 = D1W'(1);
    ctl_4  = '{status: ST_OK, vneg: 1'b0, raw: 1'b0, zero: 1'b1, den2: D2W'(1)};
    if (mode_3_r > MODE_CV) begin
      // unused request: zero, status ok
    end else if (n_3_r == '0) begin
      ctl_4.status = ST_ZERO_COUNT;
    end else if (n_3_r == COUNT_BITS'(1)) begin
      // single sample: raw gives S2, rmsd forms give sqrt(S2), others zero
      if (mode_3_r == MODE_RAW) begin
        ctl_4.raw  = 1'b1;
        ctl_4.zero = 1'b0;
        num_4      = NUMW'(s2_3_r) << FRAC_BITS;
      end else if (mode_3_r == MODE_RMSD || mode_3_r == MODE_NRMSD) begin
        ctl_4.zero = 1'b0;
        num_4      = NUMW'(s2_3_r) << (2 * FRAC_BITS);
      end
    end else if (mode_3_r == MODE_RAW) begin
      ctl_4.raw    = 1'b1;
      ctl_4.zero   = 1'b0;
      ctl_4.vneg   = dneg_3_r;
      ctl_4.status = dneg_3_r ? ST_NEG_VAR : ST_OK;
      num_4        = NUMW'(d_3_r) << FRAC_BITS;
    end else if (dneg_3_r) begin
      ctl_4.status = ST_NEG_VAR;
    end else if ((mode_3_r == MODE_NRMSD || mode_3_r == MODE_CV) && a_3_r == '0) begin
      ctl_4.status = ST_ZERO_MEAN;
    end else begin
      ctl_4.zero = 1'b0;
      case (mode_3_r)
        MODE_RMSD: begin
          num_4      = NUMW'(d_3_r) << (2 * FRAC_BITS);
          ctl_4.den2 = D2W'(n_3_r);
        end
        MODE_STDEV: begin
          num_4  = NUMW'(d_3_r) << (2 * FRAC_BITS);
          den1_4 = nn1_3_r;
        end
        MODE_NRMSD: begin
          num_4      = NUMW'(d_3_r) << (2 * FRAC_BITS);
          ctl_4.den2 = D2W'(a_3_r);
          ctl_4.vneg = sneg_3_r;
        end
        default: begin
          // coefficient of variation
          num_4      = NUMW'(dn) << (2 * FRAC_BITS);
          den1_4     = D1W'(n_3_r - COUNT_BITS'(1));
          ctl_4.den2 = D2W'(a_3_r);
          ctl_4.vneg = sneg_3_r;
        end
      endcase
    end
  end

  // ---------------- pre-divide
  logic            pre_valid;
  logic [NUMW-1:0] pre_quo;
  logic            pre_rem_zero;
  ctl_t            pre_ctl;

  vfrs_div #(
    .NW  (NUMW),
    .DENW(D1W),
    .SBW ($bits(ctl_t))
  ) u_pre_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (v3_r),
    .in_num      (num_4),
    .in_den      (den1_4),
    .in_sb       (ctl_4),
    .out_valid   (pre_valid),
    .out_quo     (pre_quo),
    .out_rem_zero(pre_rem_zero),
    .out_sb      (pre_ctl)
  );

  // ---------------- square root
  tail_t         sq_in_sb, sq_out_sb;
  logic          sq_valid;
  logic [RW-1:0] sq_root;
  logic          sq_exact;

  always_comb begin
    sq_in_sb.ctl  = pre_ctl;
    sq_in_sb.ex   = pre_rem_zero;
    sq_in_sb.rawv = RAWW'(pre_quo);
  end

  vfrs_sqrt #(
    .XW (XW),
    .SBW($bits(tail_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (pre_valid),
    .in_x     (XW'(pre_quo)),
    .in_sb    (sq_in_sb),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_exact(sq_exact),
    .out_sb   (sq_out_sb)
  );

  // ---------------- post-divide by n, by |S| or by one
  tail_t         post_in_sb, post_sb;
  logic          post_valid;
  logic [RW-1:0] post_quo;
  logic          post_rem_zero;

  always_comb begin
    post_in_sb    = sq_out_sb;
    post_in_sb.ex = sq_out_sb.ex & sq_exact;
  end

  vfrs_div #(
    .NW  (RW),
    .DENW(D2W),
    .SBW ($bits(tail_t))
  ) u_post_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (sq_valid),
    .in_num      (sq_root),
    .in_den      (sq_out_sb.ctl.den2),
    .in_sb       (post_in_sb),
    .out_valid   (post_valid),
    .out_quo     (post_quo),
    .out_rem_zero(post_rem_zero),
    .out_sb      (post_sb)
  );

  // ---------------- final magnitude: floor of a negative quotient rounds away
  logic                vf_r;
  logic [MW-1:0]       mag_f_r, mag_f_nxt;
  logic                vneg_f_r;
  logic [STATUS_W-1:0] status_f_r;
  logic                adj;

  always_comb begin
    adj       = post_sb.ctl.vneg & ~(post_sb.ex & post_rem_zero);
    mag_f_nxt = MW'(post_quo) + MW'(adj);
    if (post_sb.ctl.raw) begin
      mag_f_nxt = MW'(post_sb.rawv);
    end
    if (post_sb.ctl.zero) begin
      mag_f_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= post_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_f_r    <= mag_f_nxt;
      vneg_f_r   <= post_sb.ctl.vneg;
      status_f_r <= post_sb.ctl.status;
    end
  end

  // ---------------- saturate, apply sign, output register
  logic            out_valid_r;
  out_item_t       out_item_r, out_item_nxt;
  logic [CW-1:0]   limit;
  logic            sat;

  always_comb begin
    limit = vneg_f_r ? CW'({1'b1, {(RESULT_W-1){1'b0}}})
                     : CW'({1'b0, {(RESULT_W-1){1'b1}}});
    sat   = (CW'(mag_f_r) > limit);
    out_item_nxt.status = status_f_r;
    if (sat) begin
      out_item_nxt.result_value = limit[RESULT_W-1:0];
      if (status_f_r == ST_OK) begin
        out_item_nxt.status = ST_SAT;
      end
    end else if (vneg_f_r) begin
      out_item_nxt.result_value = RESULT_W'(0) - mag_f_r[RESULT_W-1:0];
    end else begin
      out_item_nxt.result_value = mag_f_r[RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: tb/variance_from_running_sums_tb.sv
// Self-checking testbench for variance_from_running_sums: random and directed items.
module variance_from_running_sums_tb;
  import vfrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef bit [255:0] wide_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  variance_from_running_sums dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Items waiting to be offered, and results predicted for accepted items.
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  in_taken;
  bit  hold_on;
  int  hold_cnt;
  int  mismatches;
  bit  failed;
  longint cycle_cnt;

  localparam longint CYCLE_LIMIT = 400000;
  localparam int     HOLD_CYCLES = 600;
  localparam int     PIPE_DRAIN  = 300;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Floor square root, digit by digit.
  function automatic wide_t floor_sqrt(wide_t x);
    wide_t op;
    wide_t root;
    wide_t bitv;
    op   = x;
    root = '0;
    bitv = wide_t'(1) << 254;
    while (bitv != 0 && bitv > op) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (op >= root + bitv) begin
        op   = op - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // floor(+-x / a) given r = floor(x) and whether x was an integer.
  function automatic wide_t floor_ratio(wide_t r, bit exact, wide_t a, bit neg);
    wide_t quo;
    quo = r / a;
    if (neg && !(exact && (r % a) == 0)) quo = quo + 1;
    return quo;
  endfunction

  // Exact spread statistic for one item: Q.FRAC_BITS_DEF, rounded down, saturated.
  function automatic out_item_t spread_of(in_item_t it);
    wide_t s2, n, a, p, q, d, t, r, den, mag;
    bit    sneg, dneg, vneg, ex;
    logic [STATUS_W-1:0] st;
    bit [63:0] lim;
    out_item_t res;
    s2   = wide_t'(it.sum_sq);
    n    = wide_t'(it.num_samples);
    sneg = it.sum_values[SUM_VAL_W-1];
    a    = sneg ? wide_t'(64'h1_0000_0000 - {32'd0, it.sum_values}) :
                  wide_t'({1'b0, it.sum_values});
    st   = ST_OK;
    vneg = 1'b0;
    mag  = '0;
    if (it.req_type > MODE_CV) begin
      // unused request code: zero, status ok
    end else if (n == 0) begin
      st = ST_ZERO_COUNT;
    end else if (n == 1) begin
      // single sample: the recorded special values
      if (it.req_type == MODE_RAW) mag = s2 << FRAC_BITS_DEF;
      else if (it.req_type == MODE_RMSD || it.req_type == MODE_NRMSD)
        mag = floor_sqrt(s2 << (2 * FRAC_BITS_DEF));
    end else begin
      p    = n * s2;
      q    = a * a;
      dneg = p < q;
      d    = dneg ? q - p : p - q;
      if (it.req_type == MODE_RAW) begin
        mag  = d << FRAC_BITS_DEF;
        vneg = dneg;
        if (dneg) st = ST_NEG_VAR;
      end else if (dneg) begin
        st = ST_NEG_VAR;
      end else if ((it.req_type == MODE_NRMSD || it.req_type == MODE_CV) && a == 0) begin
        st = ST_ZERO_MEAN;
      end else if (it.req_type == MODE_RMSD) begin
        mag = floor_sqrt(d << (2 * FRAC_BITS_DEF)) / n;
      end else if (it.req_type == MODE_STDEV) begin
        mag = floor_sqrt((d << (2 * FRAC_BITS_DEF)) / (n * (n - 1)));
      end else if (it.req_type == MODE_NRMSD) begin
        t    = d << (2 * FRAC_BITS_DEF);
        r    = floor_sqrt(t);
        ex   = (r * r == t);
        mag  = floor_ratio(r, ex, a, sneg);
        vneg = sneg;
      end else begin
        t    = (d * n) << (2 * FRAC_BITS_DEF);
        den  = n - 1;
        q    = t / den;
        r    = floor_sqrt(q);
        ex   = (r * r == q) && (t % den == 0);
        mag  = floor_ratio(r, ex, a, sneg);
        vneg = sneg;
      end
    end
    lim = vneg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (mag[255:64] != 0 || mag[63:0] > lim) begin
      res.result_value = lim;
      if (st == ST_OK) st = ST_SAT;
    end else begin
      res.result_value = vneg ? -mag[63:0] : mag[63:0];
    end
    res.status = st;
    return res;
  endfunction

  function automatic in_item_t mk_item(logic [SUM_SQ_W-1:0] s2, logic [SUM_VAL_W-1:0] sv,
                                       logic [COUNT_W-1:0] n, logic [REQ_W-1:0] m);
    in_item_t it;
    it.sum_sq      = s2;
    it.sum_values  = sv;
    it.num_samples = n;
    it.req_type    = m;
    return it;
  endfunction

  // Random item: mostly sums built from real 16-bit samples, some raw noise.
  function automatic in_item_t rand_item();
    longint  n, s, s2, v, dv;
    int      k, pick;
    logic [REQ_W-1:0] m;
    m    = REQ_W'(($urandom_range(99) < 94) ? $urandom_range(4) : $urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 45) begin
      // a handful of explicit samples
      n = $urandom_range(1, 12);
      s = 0; s2 = 0;
      for (k = 0; k < n; k++) begin
        v  = ($urandom_range(3) == 0) ? longint'($signed(16'($urandom))) :
                                        longint'($urandom_range(0, 40)) - 10;
        s  = s + v;
        s2 = s2 + v * v;
      end
      return mk_item(SUM_SQ_W'(s2), SUM_VAL_W'(s), COUNT_W'(n), m);
    end else if (pick < 70) begin
      // many samples around a center value with a spread
      n  = ($urandom_range(9) == 0) ? 65535 : $urandom_range(2, 3000);
      v  = longint'($signed(16'($urandom))) / (1 << $urandom_range(0, 15));
      dv = $urandom_range(0, 200);
      if (v + dv > 32767) v = 32767 - dv;
      // half the samples at v-dv, half at v+dv
      s  = n * v;
      s2 = n * (v * v + dv * dv);
      if (n % 2 == 1) begin
        s  = s - dv;
        s2 = s2 - dv * dv + 0;
        s2 = s2 - 2 * v * dv + 0;
        s2 = (n - 1) * (v * v + dv * dv) + (v - dv) * (v - dv) + 0;
        s2 = s2 - (v - dv) * (v - dv) + (v - dv) * (v - dv);
        s  = (n - 1) * v + (v - dv);
        s2 = (n - 1) * (v * v + dv * dv) + (v - dv) * (v - dv);
      end
      return mk_item(SUM_SQ_W'(s2), SUM_VAL_W'(s), COUNT_W'(n), m);
    end else if (pick < 80) begin
      // perfect-square friendly: all samples equal, zero spread
      n = $urandom_range(1, 500);
      v = longint'($signed(16'($urandom)));
      return mk_item(SUM_SQ_W'(n * v * v), SUM_VAL_W'(n * v), COUNT_W'(n), m);
    end else begin
      // unrelated raw fields, full width
      return mk_item(SUM_SQ_W'({$urandom, $urandom}), $urandom,
                     COUNT_W'($urandom_range(1) ? $urandom_range(0, 3) : $urandom), m);
    end
  endfunction

  // Sender: items change on the falling edge; a stalled item is held.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or one long hold-off for the pressure phase.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_on && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on input acceptance, compare on output acceptance.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    in_taken  <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_results.push_back(spread_of(in_item));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        failed <= 1'b1;
        if (mismatches < 10)
          $display("unexpected result value=%0d status=%0d",
                   out_item.result_value, out_item.status);
        mismatches <= mismatches + 1;
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (exp_r.result_value !== out_item.result_value || exp_r.status !== out_item.status)
        begin
          failed <= 1'b1;
          if (mismatches < 10)
            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                     exp_r.result_value, exp_r.status,
                     out_item.result_value, out_item.status);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) pending_items.push_back(rand_item());
    wait (pending_items.size() == 0 && !in_valid);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_taken       = 1'b0;
    hold_on        = 1'b0;
    hold_cnt       = 0;
    mismatches     = 0;
    failed         = 1'b0;
    cycle_cnt      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every request code, count extremes, sign and range edges
    for (int m = 0; m < 8; m++)
      pending_items.push_back(mk_item(46'd1000, 32'd10, 16'd4, REQ_W'(m)));
    pending_items.push_back(mk_item('1, 32'h8000_0000, 16'd0, MODE_RAW));      // zero count
    pending_items.push_back(mk_item('1, 32'h7fff_ffff, 16'd1, MODE_RAW));      // single sample
    pending_items.push_back(mk_item(46'd2, 32'd0, 16'd1, MODE_RMSD));
    pending_items.push_back(mk_item('1, 32'd0, 16'd1, MODE_NRMSD));
    pending_items.push_back(mk_item(46'd7, 32'd3, 16'd1, MODE_STDEV));
    pending_items.push_back(mk_item(46'd7, 32'd3, 16'd1, MODE_CV));
    pending_items.push_back(mk_item(46'd0, 32'd5, 16'd2, MODE_RAW));           // negative D
    pending_items.push_back(mk_item(46'd0, 32'h8000_0000, 16'd2, MODE_RAW));
    pending_items.push_back(mk_item(46'd0, -32'sd5, 16'd2, MODE_STDEV));
    pending_items.push_back(mk_item(46'd50, 32'd0, 16'd2, MODE_NRMSD));        // zero mean
    pending_items.push_back(mk_item(46'd50, 32'd0, 16'd2, MODE_CV));
    pending_items.push_back(mk_item('1, 32'd0, 16'hffff, MODE_RAW));           // saturates
    pending_items.push_back(mk_item('1, 32'd1, 16'hffff, MODE_NRMSD));
    pending_items.push_back(mk_item('1, -32'sd1, 16'hffff, MODE_CV));
    pending_items.push_back(mk_item(46'd41, -32'sd7, 16'd3, MODE_NRMSD));      // negative mean
    pending_items.push_back(mk_item(46'd41, -32'sd7, 16'd3, MODE_CV));
    pending_items.push_back(mk_item('1, 32'h7fff_ffff, 16'hffff, MODE_STDEV));
    run_phase(0, 0, 300);
    run_phase(70, 0, 300);
    run_phase(0, 70, 300);
    run_phase(7, 7, 400);
    // long receiver hold-off while the sender keeps offering
    hold_on = 1'b1;
    run_phase(0, 0, 500);

    wait (expected_results.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
